[rtl/sha256_stream_hasher_core_defines.svh]
// Assertion macros for the SHA-256 stream hasher core
`ifndef SHA256_STREAM_HASHER_CORE_DEFINES_SVH
`define SHA256_STREAM_HASHER_CORE_DEFINES_SVH

// same-cycle implication
`define SHS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SHS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/shs_pkg.sv]
// Shared types, constants and functions for the SHA-256 stream hasher
`default_nettype none
package shs_pkg;

  typedef logic [7:0][31:0] hash_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ROUND = 5'b00010,
    S_FOLD  = 5'b00100,
    S_PAD   = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  typedef struct packed {
    logic       push;
    logic [7:0] data;
    logic       step;
  } buf_ctl_t;

  localparam logic [7:0] PAD_MARK   = 8'h80;
  localparam logic [7:0] PAD_ZERO   = 8'h00;
  localparam logic [5:0] LEN_START  = 6'd56;
  localparam logic [5:0] FILL_LAST  = 6'd63;
  localparam logic [5:0] ROUND_LAST = 6'd63;
  localparam logic [2:0] WORD_LAST  = 3'd7;

  localparam hash_t INIT_H = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    logic [63:0] d;
    d = {x, x} >> n;
    return d[31:0];
  endfunction

  function automatic logic [31:0] big_s0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_s1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_s0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_s1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage
`default_nettype wire

[rtl/sha256_stream_hasher_core.sv]
// SHA-256 stream hasher top level: sequencer, chaining words and digest output
//
//  channel | direction | handshake           | payload
//  msg     | in        | msg_valid/msg_stall | data_byte, byte_valid, last
//  dig     | out       | dig_valid/dig_stall | digest_word, word_index, last_word
//
// A message byte transfer completes whenever msg_stall is low; the byte that completes a
// block starts 64 rounds through the one round unit, then the chaining add.
// A transfer with last set runs padding at one byte a cycle (paused during each compression),
// one or two more compressions, then eight digest transfers; msg_stall stays high meanwhile.
// Synchronous active-high reset loads the initial hash and clears all counters.
// dig_stall holds the current digest word until it is taken.
`default_nettype none
`include "sha256_stream_hasher_core_defines.svh"
module sha256_stream_hasher_core
  import shs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        msg_valid,
  output logic        msg_stall,
  input  logic [7:0]  data_byte,
  input  logic        byte_valid,
  input  logic        last,
  output logic        dig_valid,
  input  logic        dig_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  state_t      state;
  hash_t       chain;
  hash_t       chain_sum;
  hash_t       st;
  hash_t       st_next;
  logic [5:0]  rnd;
  logic [5:0]  fill;
  logic [60:0] len;
  logic        pad_active;
  logic        pad_done;
  logic        mark_sent;
  logic        in_len;
  logic [2:0]  lidx;
  logic [2:0]  oidx;
  logic        accept;
  logic        len_phase;
  logic [7:0]  pad_byte;
  logic [31:0] w0;
  buf_ctl_t    bctl;

  assign accept    = msg_valid && (state == S_IDLE);
  assign msg_stall = (state != S_IDLE);
  assign len_phase = in_len || (fill == LEN_START);

  always_comb begin
    if (!mark_sent) begin
      pad_byte = PAD_MARK;
    end else if (len_phase) begin
      pad_byte = len[60:53];
    end else begin
      pad_byte = PAD_ZERO;
    end
  end

  always_comb begin
    bctl.push = (accept && byte_valid) || (state == S_PAD);
    bctl.data = (state == S_PAD) ? pad_byte : data_byte;
    bctl.step = (state == S_ROUND);
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      chain_sum[i] = chain[i] + st[i];
    end
  end

  shs_msgbuf u_msgbuf (
    .clk (clk),
    .ctl (bctl),
    .w0  (w0)
  );

  shs_round u_round (
    .st      (st),
    .w       (w0),
    .k       (ROUND_K[rnd]),
    .st_next (st_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      chain      <= INIT_H;
      rnd        <= '0;
      fill       <= '0;
      len        <= '0;
      pad_active <= 1'b0;
      pad_done   <= 1'b0;
      mark_sent  <= 1'b0;
      in_len     <= 1'b0;
      lidx       <= '0;
      oidx       <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            pad_active <= last;
            if (byte_valid) begin
              len  <= len + 61'd1;
              fill <= fill + 6'd1;
            end
            if (byte_valid && (fill == FILL_LAST)) begin
              state <= S_ROUND;
              rnd   <= '0;
            end else if (last) begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          fill <= fill + 6'd1;
          if (!mark_sent) begin
            mark_sent <= 1'b1;
          end else if (len_phase) begin
            in_len <= 1'b1;
            len    <= {len[52:0], 8'h00};
            lidx   <= lidx + 3'd1;
            if (lidx == WORD_LAST) begin
              pad_done <= 1'b1;
            end
          end
          if (fill == FILL_LAST) begin
            state <= S_ROUND;
            rnd   <= '0;
          end
        end
        S_ROUND: begin
          rnd <= rnd + 6'd1;
          if (rnd == ROUND_LAST) begin
            state <= S_FOLD;
          end
        end
        S_FOLD: begin
          chain <= chain_sum;
          if (pad_done) begin
            state <= S_EMIT;
            oidx  <= '0;
          end else if (pad_active) begin
            state <= S_PAD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (!dig_stall) begin
            if (oidx == WORD_LAST) begin
              state      <= S_IDLE;
              chain      <= INIT_H;
              len        <= '0;
              pad_active <= 1'b0;
              pad_done   <= 1'b0;
              mark_sent  <= 1'b0;
              in_len     <= 1'b0;
              lidx       <= '0;
            end else begin
              oidx <= oidx + 3'd1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // working variables: load from chain until the rounds start
  always_ff @(posedge clk) begin
    if (state == S_ROUND) begin
      st <= st_next;
    end else begin
      st <= chain;
    end
  end

  assign dig_valid   = (state == S_EMIT);
  assign digest_word = chain[oidx];
  assign word_index  = oidx;
  assign last_word   = (oidx == WORD_LAST);

  `SHS_ASSERT_IMP(a_no_input_during_digest, clk, rst, dig_valid, msg_stall, "input taken while digest pending")
  `SHS_ASSERT_IMP(a_block_aligned_at_digest, clk, rst, dig_valid, fill == 6'd0, "digest with partial block")
  `SHS_ASSERT_NXT(a_word_index_steps, clk, rst, dig_valid && !dig_stall && !last_word, dig_valid && (word_index == $past(word_index) + 3'd1), "digest word skipped")

endmodule
`default_nettype wire

[rtl/shs_msgbuf.sv]
// Block byte buffer and rolling 16-word message schedule window
`default_nettype none
module shs_msgbuf
  import shs_pkg::*;
(
  input  logic        clk,
  input  buf_ctl_t    ctl,
  output logic [31:0] w0
);

  // oldest word in the top 32 bits
  logic [511:0] line;
  logic [31:0]  w1;
  logic [31:0]  w9;
  logic [31:0]  w14;
  logic [31:0]  wnew;

  assign w0   = line[511:480];
  assign w1   = line[479:448];
  assign w9   = line[223:192];
  assign w14  = line[63:32];
  assign wnew = w0 + small_s0(w1) + w9 + small_s1(w14);

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      line <= {line[479:0], wnew};
    end else if (ctl.push) begin
      line <= {line[503:0], ctl.data};
    end
  end

endmodule
`default_nettype wire

[rtl/shs_round.sv]
// One SHA-256 compression round, shared over all 64 rounds
`default_nettype none
module shs_round
  import shs_pkg::*;
(
  input  hash_t       st,
  input  logic [31:0] w,
  input  logic [31:0] k,
  output hash_t       st_next
);

  logic [31:0] ch;
  logic [31:0] maj;
  logic [31:0] t1;
  logic [31:0] t2;

  assign ch  = (st[4] & st[5]) ^ (~st[4] & st[6]);
  assign maj = (st[0] & st[1]) ^ (st[0] & st[2]) ^ (st[1] & st[2]);
  assign t1  = st[7] + big_s1(st[4]) + ch + k + w;
  assign t2  = big_s0(st[0]) + maj;

  always_comb begin
    st_next[0] = t1 + t2;
    st_next[1] = st[0];
    st_next[2] = st[1];
    st_next[3] = st[2];
    st_next[4] = st[3] + t1;
    st_next[5] = st[4];
    st_next[6] = st[5];
    st_next[7] = st[6];
  end

endmodule
`default_nettype wire

[bench/sha256_digest_checker.sv]
// Checker for the SHA-256 stream hasher: tracks message transfers, predicts digests, compares
`default_nettype none
module sha256_digest_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        msg_valid,
  input  logic        msg_stall,
  input  logic [7:0]  data_byte,
  input  logic        byte_valid,
  input  logic        last,
  input  logic        dig_valid,
  input  logic        dig_stall,
  input  logic [31:0] digest_word,
  input  logic [2:0]  word_index,
  input  logic        last_word,
  output int unsigned mismatches,
  output int unsigned beats_due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        fin;
  } digest_beat_t;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  logic [31:0]  chain [8];
  logic [7:0]   blk [64];
  int unsigned  fill;
  logic [63:0]  msg_bytes;
  digest_beat_t digest_beats_due [$];

  function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void restart_hash();
    for (int i = 0; i < 8; i++) chain[i] = IV[i];
    fill = 0;
    msg_bytes = '0;
  endfunction

  function automatic void mix_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + w[i-7]
           + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3))
           + (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RK[i] + w[i];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
  endfunction

  function automatic void take_byte(input logic [7:0] b);
    blk[fill] = b;
    fill++;
    if (fill == 64) begin
      mix_block();
      fill = 0;
    end
  endfunction

  function automatic void absorb_transfer(input logic [7:0] b, input logic bv, input logic fin);
    logic [63:0] bit_len;
    digest_beat_t beat;
    if (bv) begin
      msg_bytes++;
      take_byte(b);
    end
    if (fin) begin
      bit_len = msg_bytes << 3;
      take_byte(8'h80);
      while (fill != 56) take_byte(8'h00);
      for (int i = 0; i < 8; i++) take_byte(bit_len[63 - 8*i -: 8]);
      for (int i = 0; i < 8; i++) begin
        beat.word = chain[i];
        beat.idx  = 3'(i);
        beat.fin  = (i == 7);
        digest_beats_due.push_back(beat);
      end
      restart_hash();
    end
  endfunction

  always @(posedge clk) begin
    digest_beat_t want;
    if (rst) begin
      restart_hash();
      digest_beats_due.delete();
      mismatches = 0;
    end else begin
      if (msg_valid && !msg_stall) absorb_transfer(data_byte, byte_valid, last);
      if (dig_valid && !dig_stall) begin
        if (digest_beats_due.size() == 0) begin
          $display("%0t: unexpected digest transfer: expected none, got word %h index %0d last %b",
                   $time, digest_word, word_index, last_word);
          mismatches++;
        end else begin
          want = digest_beats_due.pop_front();
          if (digest_word !== want.word) begin
            $display("%0t: digest word %0d: expected %h, got %h",
                     $time, want.idx, want.word, digest_word);
            mismatches++;
          end
          if (word_index !== want.idx) begin
            $display("%0t: word index: expected %0d, got %0d", $time, want.idx, word_index);
            mismatches++;
          end
          if (last_word !== want.fin) begin
            $display("%0t: last word flag at word %0d: expected %b, got %b",
                     $time, want.idx, want.fin, last_word);
            mismatches++;
          end
        end
      end
    end
    beats_due = digest_beats_due.size();
  end

endmodule
`default_nettype wire

[bench/tb_sha256_stream_hasher_core.sv]
// Testbench top for the SHA-256 stream hasher: message stimulus, digest back-pressure, verdict
`default_nettype none
module tb_sha256_stream_hasher_core;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst;
  logic        msg_valid;
  logic        msg_stall;
  logic [7:0]  data_byte;
  logic        byte_valid;
  logic        last;
  logic        dig_valid;
  logic        dig_stall;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  int unsigned mismatches;
  int unsigned beats_due;
  int unsigned items_sent;
  bit          quiet_sender;
  bit          quiet_sink;

  sha256_stream_hasher_core dut (
    .clk         (clk),
    .rst         (rst),
    .msg_valid   (msg_valid),
    .msg_stall   (msg_stall),
    .data_byte   (data_byte),
    .byte_valid  (byte_valid),
    .last        (last),
    .dig_valid   (dig_valid),
    .dig_stall   (dig_stall),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
  );

  sha256_digest_checker digest_check (
    .clk         (clk),
    .rst         (rst),
    .msg_valid   (msg_valid),
    .msg_stall   (msg_stall),
    .data_byte   (data_byte),
    .byte_valid  (byte_valid),
    .last        (last),
    .dig_valid   (dig_valid),
    .dig_stall   (dig_stall),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word),
    .mismatches  (mismatches),
    .beats_due   (beats_due)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_item(input logic [7:0] b, input logic bv, input logic fin);
    int unsigned gap;
    gap = quiet_sender ? 0 : pick_gap();
    if (gap != 0) begin
      msg_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    msg_valid  <= 1'b1;
    data_byte  <= b;
    byte_valid <= bv;
    last       <= fin;
    @(posedge clk);
    while (msg_stall) @(posedge clk);
    if (bv || fin) items_sent++;
    @(negedge clk);
  endtask

  task automatic send_message(input int unsigned nbytes, input bit end_apart);
    if (nbytes == 0) begin
      send_item(8'($urandom), 1'b0, 1'b1);
      return;
    end
    for (int unsigned k = 0; k < nbytes; k++) begin
      if ($urandom_range(0, 9) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, (k == nbytes - 1) && !end_apart);
    end
    if (end_apart) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic drain_digests();
    msg_valid <= 1'b0;
    @(negedge clk);
    while (beats_due != 0) @(negedge clk);
  endtask

  function automatic int unsigned pick_length();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(0, 12);
    if (r < 8) begin
      case ($urandom_range(0, 5))
        0: return 55;
        1: return 56;
        2: return 57;
        3: return 63;
        4: return 64;
        default: return 65;
      endcase
    end
    if (r == 8) return $urandom_range(13, 140);
    case ($urandom_range(0, 2))
      0: return 119;
      1: return 120;
      default: return 128;
    endcase
  endfunction

  initial begin
    dig_stall = 1'b0;
    quiet_sink = 1'b0;
    forever begin
      if ($urandom_range(0, 199) == 0) quiet_sink = !quiet_sink;
      if (!quiet_sink && $urandom_range(0, 2) == 0) begin
        dig_stall <= 1'b1;
        repeat (pick_gap() + 1) @(negedge clk);
      end
      dig_stall <= 1'b0;
      @(negedge clk);
    end
  end

  initial begin
    #12_000_000;
    $display("sha256_stream_hasher_core regression: fail");
    $finish;
  end

  initial begin
    int unsigned msg_count;
    rst          = 1'b1;
    msg_valid    = 1'b0;
    data_byte    = 8'h00;
    byte_valid   = 1'b0;
    last         = 1'b0;
    items_sent   = 0;
    quiet_sender = 1'b0;
    msg_count    = 0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty message
    send_item(8'hff, 1'b0, 1'b1);
    // extreme bytes, end on the data transfer
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hff, 1'b1, 1'b1);
    // "abc" with an idle transfer in the middle
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h5a, 1'b0, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    // message closed by a separate end-only transfer
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h7f, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    // back-to-back empty messages
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h00, 1'b0, 1'b1);
    drain_digests();

    while (items_sent < 420) begin
      if ($urandom_range(0, 4) == 0) quiet_sender = !quiet_sender;
      send_message(pick_length(), $urandom_range(0, 3) == 0);
      msg_count++;
      if (msg_count % 6 == 0) drain_digests();
    end

    msg_valid <= 1'b0;
    @(negedge clk);
    while (beats_due != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (mismatches == 0)
      $display("sha256_stream_hasher_core regression: pass");
    else
      $display("sha256_stream_hasher_core regression: fail");
    $finish;
  end

endmodule
`default_nettype wire

[sha256_stream_hasher_core.f]
+incdir+rtl
rtl/shs_pkg.sv
rtl/shs_msgbuf.sv
rtl/shs_round.sv
rtl/sha256_stream_hasher_core.sv
bench/sha256_digest_checker.sv
bench/tb_sha256_stream_hasher_core.sv
